/* rtl/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and codes for the symmetric sparse residual unit.
// ----------------------------------------------------------------------------
package ssr_pkg;

  // Input function codes
  localparam logic [2:0] FN_LDX    = 3'd0;
  localparam logic [2:0] FN_LDB    = 3'd1;
  localparam logic [2:0] FN_ENTRY  = 3'd2;
  localparam logic [2:0] FN_FINISH = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;

  // Classified operation codes carried through the queue
  localparam logic [2:0] OP_LDX  = 3'd0;
  localparam logic [2:0] OP_LDB  = 3'd1;
  localparam logic [2:0] OP_ENT  = 3'd2;
  localparam logic [2:0] OP_FIN  = 3'd3;
  localparam logic [2:0] OP_RD   = 3'd4;
  localparam logic [2:0] OP_RDZ  = 3'd5;

  localparam logic [8:0] VSIZE_RESET = 9'd256;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         row;
    logic [7:0]         col;
    logic               diag;
    logic signed [31:0] value;
  } ssr_item_t;

endpackage

/* rtl/symmetric_sparse_residual_unit.sv */
// ----------------------------------------------------------------------------
// symmetric_sparse_residual_unit
// Residual r = b - K*x of a symmetric sparse matrix and its infinity norm.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  in       in   in_valid/in_ready   in_func, in_row_index, in_col_index, in_value
//  out      out  out_valid/out_ready out_result_value
//  cfg      in   cfg_we              cfg_wdata (vector_size)
//
//  Loads write as they leave the queue; a matrix entry runs through E1 and E2,
//  plus E3 off the diagonal, on the shared multiplier and accumulator memory
//  port; a read runs through RD, if in range, and OUT. Finish sweeps all
//  MAX_DIM entries one per cycle. A two-word queue decouples input from
//  execution; results wait in an output register. Reset starts a clearing
//  pass that zeroes the memories; queued words wait until it ends.
// ----------------------------------------------------------------------------
module symmetric_sparse_residual_unit #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_row_index,
  input  logic [7:0]         in_col_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value
);
  import ssr_pkg::*;

  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int CW = (NW > 9) ? NW : 9;

  logic [8:0]    vsize_r;
  logic [CW-1:0] n;
  logic          q_valid, q_pop;
  ssr_item_t     q_head;

  // Hold the size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsize_r <= VSIZE_RESET;
    end else if (cfg_we) begin
      vsize_r <= cfg_wdata;
    end
  end

  // Clamp the size to the memory depth
  assign n = (CW'(vsize_r) < CW'(MAX_DIM)) ? CW'(vsize_r) : CW'(MAX_DIM);

  ssr_front #(.CW(CW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .n            (n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  ssr_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .n                (n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value)
  );

endmodule

/* rtl/ssr_front.sv */
// ----------------------------------------------------------------------------
// ssr_front
// Accepts input words, drops ignored ones and queues classified operations.
// ----------------------------------------------------------------------------
module ssr_front #(
  parameter int CW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CW-1:0]      n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_row_index,
  input  logic [7:0]         in_col_index,
  input  logic signed [31:0] in_value,
  output logic               q_valid,
  output ssr_pkg::ssr_item_t q_head,
  input  logic               q_pop
);
  import ssr_pkg::*;

  ssr_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  ssr_item_t  item;
  logic       keep, row_ok, col_ok, push;

  // Classify the incoming word
  always_comb begin
    row_ok     = CW'(in_row_index) < n;
    col_ok     = CW'(in_col_index) < n;
    item.row   = in_row_index;
    item.col   = in_col_index;
    item.diag  = in_row_index == in_col_index;
    item.value = in_value;
    item.op    = OP_LDX;
    keep       = 1'b0;
    case (in_func)
      FN_LDX: begin
        item.op = OP_LDX;
        keep    = row_ok;
      end
      FN_LDB: begin
        item.op = OP_LDB;
        keep    = row_ok;
      end
      FN_ENTRY: begin
        item.op = OP_ENT;
        keep    = row_ok && col_ok;
      end
      FN_FINISH: begin
        item.op = OP_FIN;
        keep    = 1'b1;
      end
      FN_READ: begin
        item.op = row_ok ? OP_RD : OP_RDZ;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = cnt_r != 2'd2;
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = cnt_r != 2'd0;
  assign q_head   = mem_r[rp_r];

  // Store queued operations
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

/* rtl/ssr_back.sv */
// ----------------------------------------------------------------------------
// ssr_back
// Executes queued operations on the x, b, y and residual memories.
// ----------------------------------------------------------------------------
module ssr_back #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 16,
  parameter int CW        = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CW-1:0]      n,
  input  logic               q_valid,
  input  ssr_pkg::ssr_item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value
);
  import ssr_pkg::*;

  localparam int AW = $clog2(MAX_DIM);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_E1   = 3'd1;
  localparam logic [2:0] ST_E2   = 3'd2;
  localparam logic [2:0] ST_E3   = 3'd3;
  localparam logic [2:0] ST_SWP  = 3'd4;
  localparam logic [2:0] ST_DRN  = 3'd5;
  localparam logic [2:0] ST_RD   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]         st_r, st_nxt;
  ssr_item_t          op_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] xr_r;
  logic [47:0]        yq_r;
  logic [AW-1:0]      k_r;
  logic               s1_v_r, s2_v_r;
  logic [AW-1:0]      s1_k_r;
  logic [31:0]        mag_r, norm_r, res_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic               clr_r;
  logic [AW-1:0]      clr_k_r;

  // Memories and read data
  logic [31:0] x_mem [MAX_DIM];
  logic [31:0] b_mem [MAX_DIM];
  logic [47:0] y_mem [MAX_DIM];
  logic [31:0] r_mem [MAX_DIM];
  logic [31:0] xa_q, xb_q, b_q, r_q;
  logic [47:0] y_q;

  logic [AW-1:0] head_row, head_col, op_row, op_col, y_ra, y_wa;
  logic          x_we, b_we, y_we, r_we;
  logic [47:0]   y_wd, y_base;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p, sh;
  logic signed [31:0] bb, rs_sat, rs;
  logic signed [47:0] yy;
  logic signed [48:0] diff;
  logic [31:0]   mag;
  logic          out_free;

  assign head_row = AW'(q_head.row);
  assign head_col = AW'(q_head.col);
  assign op_row   = AW'(op_r.row);
  assign op_col   = AW'(op_r.col);
  assign q_pop    = (st_r == ST_IDLE) && q_valid && !clr_r;
  assign out_free = !out_valid_r || out_ready;

  assign x_we = q_pop && (q_head.op == OP_LDX);
  assign b_we = q_pop && (q_head.op == OP_LDB);

  // Pick the accumulator address
  always_comb begin
    case (st_r)
      ST_E2:   y_ra = op_col;
      ST_SWP:  y_ra = k_r;
      default: y_ra = head_row;
    endcase
  end

  // Shared multiplier and accumulator update
  assign mul_b  = (st_r == ST_E1) ? $signed(xa_q) : xr_r;
  assign mul_p  = 64'(op_r.value) * 64'(mul_b);
  assign sh     = prod_r >>> FRAC_BITS;
  assign y_we   = (st_r == ST_E2) || (st_r == ST_E3);
  assign y_wa   = (st_r == ST_E2) ? op_row : op_col;
  assign y_base = (st_r == ST_E2) ? yq_r : y_q;
  assign y_wd   = y_base + sh[47:0];

  // Form one residual from the read stage
  always_comb begin
    bb   = $signed(b_q);
    yy   = $signed(y_q);
    diff = 49'(bb) - 49'(yy);
    if (diff[48:31] == {18{diff[48]}}) begin
      rs_sat = diff[31:0];
    end else begin
      rs_sat = diff[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    rs  = (CW'(s1_k_r) < n) ? rs_sat : 32'sd0;
    mag = rs[31] ? (~rs + 32'd1) : rs;
  end
  assign r_we = s1_v_r;

  // Sweep zeros through the memories after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= 1'b1;
      clr_k_r <= '0;
    end else if (clr_r) begin
      clr_k_r <= clr_k_r + AW'(1);
      if (clr_k_r == AW'(MAX_DIM - 1)) clr_r <= 1'b0;
    end
  end

  // Write and read the memories; zero each accumulator once the sweep read it
  always_ff @(posedge clk) begin
    if (clr_r) begin
      x_mem[clr_k_r] <= '0;
      b_mem[clr_k_r] <= '0;
      y_mem[clr_k_r] <= '0;
      r_mem[clr_k_r] <= '0;
    end else begin
      if (x_we) x_mem[head_row] <= q_head.value;
      if (b_we) b_mem[head_row] <= q_head.value;
      if (y_we) y_mem[y_wa] <= y_wd;
      else if (r_we) y_mem[s1_k_r] <= '0;
      if (r_we) r_mem[s1_k_r] <= rs;
    end
    xa_q <= x_mem[head_col];
    xb_q <= x_mem[head_row];
    b_q  <= b_mem[k_r];
    y_q  <= y_mem[y_ra];
    r_q  <= r_mem[head_row];
  end

  // Sequence the operations
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_head.op)
            OP_ENT:  st_nxt = ST_E1;
            OP_FIN:  st_nxt = ST_SWP;
            OP_RD:   st_nxt = ST_RD;
            OP_RDZ:  st_nxt = ST_OUT;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_E1:   st_nxt = ST_E2;
      ST_E2:   st_nxt = op_r.diag ? ST_IDLE : ST_E3;
      ST_E3:   st_nxt = ST_IDLE;
      ST_SWP:  st_nxt = (k_r == AW'(MAX_DIM - 1)) ? ST_DRN : ST_SWP;
      ST_DRN:  st_nxt = (!s1_v_r && !s2_v_r) ? ST_OUT : ST_DRN;
      ST_RD:   st_nxt = ST_OUT;
      ST_OUT:  st_nxt = out_free ? ST_IDLE : ST_OUT;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      s1_v_r <= st_r == ST_SWP;
      s2_v_r <= s1_v_r;
      if (st_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)             out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) op_r <= q_head;
    s1_k_r <= k_r;
    mag_r  <= mag;
    case (st_r)
      ST_IDLE: begin
        k_r    <= '0;
        norm_r <= '0;
        res_r  <= '0;
      end
      ST_E1: begin
        prod_r <= mul_p;
        xr_r   <= $signed(xb_q);
        yq_r   <= y_q;
      end
      ST_E2:  prod_r <= mul_p;
      ST_SWP: k_r <= k_r + AW'(1);
      ST_DRN: res_r <= norm_r[31] ? 32'h7fff_ffff : norm_r;
      ST_RD:  res_r <= r_q;
      ST_OUT: begin
        if (out_free) out_data_r <= res_r;
      end
      default: begin
      end
    endcase
    if (s2_v_r && (mag_r > norm_r)) norm_r <= mag_r;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_data_r;

  // Checks
  a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(s1_v_r)) else $error("residual stage out of order");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !q_pop) else $error("operation issued during clearing pass");
  a_load_vs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    x_we |-> !y_we) else $error("load overlaps accumulate");
  a_sweep_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !y_we) else $error("accumulate during sweep");

endmodule
